// ----- hw/rtl/fnc_pkg.sv -----
// Shared types, constants and the note table for the frequency-to-note block.
`timescale 1ns / 1ps

package fnc_pkg;

  // Note frequencies and the valid frequency span, unsigned with 24 fraction bits
  localparam int NOTE_FRAC = 24;
  localparam int BASE_W    = 32;   // range-0 note table entries
  localparam int NOTE_W    = 38;   // any note of ranges 0..6, and any valid frequency
  localparam int DIFF_W    = 32;   // distance to the nearest note
  localparam int FACT_W    = 27;   // cents factor width
  localparam int PROD_W    = DIFF_W + FACT_W;
  localparam int DEN_W     = NOTE_W + 16;
  localparam int REM_W     = 60;   // dividend and divisor shifted by up to six
  localparam int QUO_W     = 7;
  localparam int NUM_RANGES = 7;
  localparam int OUT_DATA_W = 24;

  localparam logic [NOTE_W-1:0] TOP_LIMIT   = 38'd144574923264;
  localparam logic [FACT_W-1:0] CENT_FACTOR = 27'd110217975;  // 100/(2^(1/12)-1), Q.16
  localparam logic [5:0]        CENT_LIMIT  = 6'd50;
  localparam logic [3:0]        LAST_NOTE   = 4'd12;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_HIGH = 2'd1,
    ST_LOW  = 2'd2
  } status_e;

  // Item handed from the classifier to the back end through the queue
  typedef struct packed {
    status_e           status;
    logic [2:0]        range;
    logic [3:0]        lo;     // highest note not above the frequency
    logic [NOTE_W-1:0] x;      // frequency in note format
  } fr_item_t;

  // Per-item control carried along the back pipeline
  typedef struct packed {
    status_e    status;
    logic [2:0] range;
    logic [3:0] best;
    logic       below;
  } bk_meta_t;

  // Range-0 notes C..next C (deep C upward)
  function automatic logic [BASE_W-1:0] base_note(input logic [3:0] idx);
    logic [BASE_W-1:0] n;
    case (idx)
      4'd0:    n = 32'd1097337155;
      4'd1:    n = 32'd1162588218;
      4'd2:    n = 32'd1231719311;
      4'd3:    n = 32'd1304961152;
      4'd4:    n = 32'd1382558180;
      4'd5:    n = 32'd1464769368;
      4'd6:    n = 32'd1551869087;
      4'd7:    n = 32'd1644148025;
      4'd8:    n = 32'd1741914154;
      4'd9:    n = 32'd1845493760;
      4'd10:   n = 32'd1955232530;
      4'd11:   n = 32'd2071496706;
      4'd12:   n = 32'd2194674310;
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

// ----- hw/rtl/frequency_to_note_and_cents.sv -----
// Top level of the frequency-to-note and cents block.
`timescale 1ns / 1ps

// Maps each measured frequency (unsigned, FREQ_FRAC_BITS fraction bits) to the
// nearest equal-tempered note: status, octave band, note index, octave label and
// cents deviation. Every input transaction produces exactly one output
// transaction, in order. The block is fully pipelined and takes one frequency
// per clock while no output back-pressure stalls it. The 14 register stages
// are: two front stages (limit check, band, bracketing note), one queue slot,
// note selection, the cents multiply, divisor setup and a seven-stage
// restoring divider that yields one quotient bit per stage, then the result
// register. A four-entry queue decouples the front from the back, so output
// back-pressure stalls only the back end until the queue fills.
module frequency_to_note_and_cents #(
  parameter int FREQ_WIDTH     = 24,
  parameter int FREQ_FRAC_BITS = 10
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // [FREQ_WIDTH-1:0] frequency, zero padded to whole bytes
  input  logic [((FREQ_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // [1:0] status, [4:2] octave_range, [8:5] note_index, [11:9] octave_label,
  // [12] label_present, [19:13] cents, [23:20] zero
  output logic [fnc_pkg::OUT_DATA_W-1:0]         m_axis_tdata_o
);
  import fnc_pkg::*;

  localparam int QUEUE_DEPTH = 4;

  logic     fq_valid, fq_ready, bq_valid, bq_ready;
  fr_item_t fq_item, bq_item;

  fnc_front #(
    .FREQ_WIDTH     (FREQ_WIDTH),
    .FREQ_FRAC_BITS (FREQ_FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_freq_i  (s_axis_tdata_i[FREQ_WIDTH-1:0]),
    .q_valid_o (fq_valid),
    .q_ready_i (fq_ready),
    .q_item_o  (fq_item)
  );

  fnc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_item_i  (fq_item),
    .pop_valid_o  (bq_valid),
    .pop_ready_i  (bq_ready),
    .pop_item_o   (bq_item)
  );

  fnc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (bq_valid),
    .q_ready_o (bq_ready),
    .q_item_i  (bq_item),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o)
  );

endmodule

// ----- hw/rtl/fnc_front.sv -----
// Front end: range check, octave band and bracketing note search (two stages).
`timescale 1ns / 1ps

module fnc_front #(
  parameter int FREQ_WIDTH     = 24,
  parameter int FREQ_FRAC_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_valid_i,
  output logic                   s_ready_o,
  input  logic [FREQ_WIDTH-1:0]  s_freq_i,
  output logic                   q_valid_o,
  input  logic                   q_ready_i,
  output fnc_pkg::fr_item_t      q_item_o
);
  import fnc_pkg::*;

  localparam int SHIFT = NOTE_FRAC - FREQ_FRAC_BITS;
  localparam int XW    = FREQ_WIDTH + SHIFT;
  localparam int CW    = (XW > NOTE_W) ? XW : NOTE_W;

  logic     adv;
  logic     v1_q, v2_q;
  fr_item_t s1_d, s1_q, s2_d, s2_q;
  logic [CW-1:0] x_ext;

  // Whole front moves when its last stage is empty or drains into the queue
  assign adv       = !v2_q || q_ready_i;
  assign s_ready_o = adv;

  // Stage 1: bring to note format, limit checks, octave band
  always_comb begin
    x_ext = CW'(s_freq_i) << SHIFT;
    s1_d.x  = x_ext[NOTE_W-1:0];
    s1_d.lo = '0;
    s1_d.range = '0;
    for (int i = 1; i < NUM_RANGES; i++) begin
      if (x_ext >= (CW'(base_note(4'd0)) << i)) s1_d.range = 3'(i);
    end
    if (x_ext > CW'(TOP_LIMIT)) begin
      s1_d.status = ST_HIGH;
    end else if (x_ext < CW'(base_note(4'd0))) begin
      s1_d.status = ST_LOW;
    end else begin
      s1_d.status = ST_OK;
    end
  end

  // Stage 2: highest note of the band that is not above the frequency
  always_comb begin
    s2_d    = s1_q;
    s2_d.lo = '0;
    for (int i = 1; i <= 12; i++) begin
      if (s1_q.x >= (NOTE_W'(base_note(4'(i))) << s1_q.range)) s2_d.lo = 4'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  assign q_valid_o = v2_q;
  assign q_item_o  = s2_q;

  // A found note never brackets past the next C
  a_lo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && s2_q.status == ST_OK) |-> (s2_q.lo <= LAST_NOTE))
    else $error("bracketing note index out of range");

endmodule

// ----- hw/rtl/fnc_fifo.sv -----
// Short queue between the front end and the back end.
`timescale 1ns / 1ps

module fnc_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  fnc_pkg::fr_item_t push_item_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output fnc_pkg::fr_item_t pop_item_o
);
  import fnc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fr_item_t         mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_ready_i && pop_valid_o;
  assign pop_item_o = mem_q[rd_q];

  // Pointer wrap and occupancy
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (pop)  rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_item_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("queue occupancy above depth");

  a_cnt_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue lost a pushed transaction");

endmodule

// ----- hw/rtl/fnc_back.sv -----
// Back end: nearest note, cents product, pipelined restoring divide, result register.
`timescale 1ns / 1ps

module fnc_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  output logic                                q_ready_o,
  input  fnc_pkg::fr_item_t                   q_item_i,
  output logic                                m_valid_o,
  input  logic                                m_ready_i,
  output logic [fnc_pkg::OUT_DATA_W-1:0]      m_data_o
);
  import fnc_pkg::*;

  localparam int DIV_STEPS = QUO_W;

  typedef struct packed {
    bk_meta_t          meta;
    logic [DIFF_W-1:0] d;
    logic [NOTE_W-1:0] note;
  } sel_t;

  typedef struct packed {
    bk_meta_t          meta;
    logic [PROD_W-1:0] prod;
    logic [NOTE_W-1:0] note;
  } mul_t;

  typedef struct packed {
    bk_meta_t         meta;
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } div_t;

  logic en;
  logic sel_v_q, mul_v_q, out_v_q;
  logic div_v_q [DIV_STEPS+1];
  sel_t sel_d, sel_q;
  mul_t mul_d, mul_q;
  div_t div_d [DIV_STEPS+1];
  div_t div_q [DIV_STEPS+1];

  // Result fields
  status_e    out_status_q, out_status_d;
  logic [2:0] out_range_q, out_range_d;
  logic [3:0] out_idx_q, out_idx_d;
  logic [2:0] out_label_q, out_label_d;
  logic       out_present_q, out_present_d;
  logic [6:0] out_cents_q, out_cents_d;

  logic [3:0]        hi_idx;
  logic [NOTE_W-1:0] n_lo, n_hi, d_lo, d_hi;
  logic [5:0]        mag;
  logic              neg;
  bk_meta_t          fin;

  // Whole back pipeline stalls only when a finished result is not taken
  assign en        = !out_v_q || m_ready_i;
  assign q_ready_o = en;

  // Nearest of the two bracketing notes; a tie keeps the lower one
  always_comb begin
    hi_idx = (q_item_i.lo == LAST_NOTE) ? q_item_i.lo : q_item_i.lo + 4'd1;
    n_lo = NOTE_W'(base_note(q_item_i.lo)) << q_item_i.range;
    n_hi = NOTE_W'(base_note(hi_idx)) << q_item_i.range;
    d_lo = q_item_i.x - n_lo;
    d_hi = n_hi - q_item_i.x;
    sel_d.meta.status = q_item_i.status;
    sel_d.meta.range  = q_item_i.range;
    if (q_item_i.lo == LAST_NOTE || d_lo <= d_hi) begin
      sel_d.meta.best  = q_item_i.lo;
      sel_d.meta.below = 1'b0;
      sel_d.d          = d_lo[DIFF_W-1:0];
      sel_d.note       = n_lo;
    end else begin
      sel_d.meta.best  = hi_idx;
      sel_d.meta.below = 1'b1;
      sel_d.d          = d_hi[DIFF_W-1:0];
      sel_d.note       = n_hi;
    end
  end

  // Distance times the cents factor
  always_comb begin
    mul_d.meta = sel_q.meta;
    mul_d.note = sel_q.note;
    mul_d.prod = PROD_W'(sel_q.d) * PROD_W'(CENT_FACTOR);
  end

  // Divide setup: add half the divisor for rounding, then one quotient bit per stage
  always_comb begin
    div_d[0].meta = mul_q.meta;
    div_d[0].rem  = REM_W'(mul_q.prod) + (REM_W'(mul_q.note) << 15);
    div_d[0].den  = DEN_W'(mul_q.note) << 16;
    div_d[0].quo  = '0;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      div_d[k] = div_q[k-1];
      if (div_q[k-1].rem >= (REM_W'(div_q[k-1].den) << (DIV_STEPS - k))) begin
        div_d[k].rem = div_q[k-1].rem - (REM_W'(div_q[k-1].den) << (DIV_STEPS - k));
        div_d[k].quo[DIV_STEPS-k] = 1'b1;
      end
    end
  end

  // Saturate, sign and octave label
  always_comb begin
    fin = div_q[DIV_STEPS].meta;
    mag = (div_q[DIV_STEPS].quo > QUO_W'(CENT_LIMIT)) ? CENT_LIMIT
                                                      : div_q[DIV_STEPS].quo[5:0];
    neg = fin.below && (mag != '0);
    out_status_d  = fin.status;
    out_range_d   = '0;
    out_idx_d     = '0;
    out_label_d   = '0;
    out_present_d = 1'b0;
    out_cents_d   = '0;
    if (fin.status == ST_OK) begin
      out_range_d = fin.range;
      out_idx_d   = fin.best;
      out_cents_d = neg ? (7'd0 - {1'b0, mag}) : {1'b0, mag};
      if (fin.best == LAST_NOTE) begin
        out_label_d   = fin.range;
        out_present_d = 1'b1;
      end else if (fin.range != '0) begin
        out_label_d   = fin.range - 3'd1;
        out_present_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_v_q <= 1'b0;
      mul_v_q <= 1'b0;
      out_v_q <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) div_v_q[k] <= 1'b0;
    end else if (en) begin
      sel_v_q    <= q_valid_i;
      mul_v_q    <= sel_v_q;
      div_v_q[0] <= mul_v_q;
      for (int k = 1; k <= DIV_STEPS; k++) div_v_q[k] <= div_v_q[k-1];
      out_v_q    <= div_v_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sel_q <= sel_d;
      mul_q <= mul_d;
      for (int k = 0; k <= DIV_STEPS; k++) div_q[k] <= div_d[k];
      out_status_q  <= out_status_d;
      out_range_q   <= out_range_d;
      out_idx_q     <= out_idx_d;
      out_label_q   <= out_label_d;
      out_present_q <= out_present_d;
      out_cents_q   <= out_cents_d;
    end
  end

  assign m_valid_o = out_v_q;
  assign m_data_o  = {(OUT_DATA_W - 20)'(0), out_cents_q, out_present_q, out_label_q,
                      out_idx_q, out_range_q, out_status_q};

  a_cents_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_status_q == ST_OK) |->
      ($signed(out_cents_q) <= 7'sd50 && $signed(out_cents_q) >= -7'sd50))
    else $error("cents outside saturation limits");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_status_q != ST_OK) |->
      (out_cents_q == '0 && !out_present_q && out_idx_q == '0))
    else $error("out-of-range result carries note data");

endmodule
